// File: hw/rtl/smf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median package
// Shared sample type, window geometry, fill counter type and rank type.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int WINDOW      = 5;
    localparam int HIST_DEPTH  = WINDOW - 1;
    localparam int MEDIAN_RANK = WINDOW / 2;
    localparam int SAMPLE_W    = 16;
    localparam int FILL_W      = $clog2(WINDOW);
    localparam int RANK_W      = $clog2(WINDOW);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [FILL_W-1:0]          t_fill;
    typedef logic [RANK_W-1:0]          t_rank;

    localparam t_fill FILL_FULL = t_fill'(HIST_DEPTH);

endpackage
`default_nettype wire

// File: hw/rtl/smf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median history cell
// One tap of the sample history; takes its neighbor's sample on each shift.
// ----------------------------------------------------------------------------
module smf_cell (
    input  wire logic              i_clk,
    input  wire logic              i_shift,
    input  wire smf_pkg::t_sample  i_sample,
    output smf_pkg::t_sample       o_sample
);
    import smf_pkg::*;

    t_sample r_sample;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule
`default_nettype wire

// File: hw/rtl/smf_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding median selector
// Rank-counting network that picks the middle element of the window.
// ----------------------------------------------------------------------------
module smf_median (
    input  wire smf_pkg::t_sample i_win [smf_pkg::WINDOW],
    output smf_pkg::t_sample      o_median
);
    import smf_pkg::*;

    // Equal values are ordered by position, so exactly one element
    // lands on the middle rank.
    always_comb begin
        t_rank   rank;
        t_sample sel;
        sel = '0;
        for (int i = 0; i < WINDOW; i++) begin
            rank = '0;
            for (int j = 0; j < WINDOW; j++) begin
                if (j != i) begin
                    if ((i_win[j] < i_win[i]) || ((i_win[j] == i_win[i]) && (j < i))) begin
                        rank = rank + t_rank'(1);
                    end
                end
            end
            if (rank == t_rank'(MEDIAN_RANK)) begin
                sel = sel | i_win[i];
            end
        end
        o_median = sel;
    end

endmodule
`default_nettype wire

// File: hw/rtl/sliding_median_of_five.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding five-tap median filter
// Streams signed samples and emits the median of the latest five.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock cycle while o_in_ready is high and
// keeps the last four in a chain of history cells that shift on every
// accepted transaction. A sample with start_req set begins a new sequence;
// the first four samples of a sequence produce no result, every later sample
// produces one median. A result passes from the window register through the
// rank-select network into the output register. Both stages advance whenever
// the downstream side has room, so throughput is one sample per cycle
// without backpressure.
module sliding_median_of_five (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire smf_pkg::t_sample  i_sample,
    input  wire logic              i_start_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output smf_pkg::t_sample       o_median
);
    import smf_pkg::*;

    t_sample hist [HIST_DEPTH];
    t_sample r_win [WINDOW];
    t_sample median;
    t_sample r_median;
    t_fill   r_fill;
    t_fill   fill_cur;
    t_fill   n_fill;
    logic    r_win_valid;
    logic    r_out_valid;
    logic    out_load;
    logic    win_load;
    logic    accept;
    logic    produce;

    assign out_load   = !r_out_valid || i_out_ready;
    assign win_load   = !r_win_valid || out_load;
    assign o_in_ready = win_load;
    assign accept     = i_in_valid && win_load;

    // A start request clears the fill count before the sample is counted.
    assign fill_cur = i_start_req ? '0 : r_fill;
    assign produce  = (fill_cur == FILL_FULL);
    assign n_fill   = produce ? fill_cur : fill_cur + t_fill'(1);

    for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_hist
        if (k == 0) begin : g_head
            smf_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (accept),
                .i_sample (i_sample),
                .o_sample (hist[k])
            );
        end else begin : g_tail
            smf_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (accept),
                .i_sample (hist[k-1]),
                .o_sample (hist[k])
            );
        end
    end

    smf_median u_median (
        .i_win    (r_win),
        .o_median (median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_win_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill <= n_fill;
            end
            if (win_load) begin
                r_win_valid <= accept && produce;
            end
            if (out_load) begin
                r_out_valid <= r_win_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win[0] <= i_sample;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_win[k+1] <= hist[k];
            end
        end
        if (out_load && r_win_valid) begin
            r_median <= median;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;

endmodule
`default_nettype wire
